/* rtl/core/assert_macros.svh */
// Assertion macros used by the file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)

`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

/* rtl/core/msbr_pkg.sv */
package msbr_pkg;

  localparam int unsigned BufferBytes = 8;
  localparam int unsigned MaxReadBits = 32;
  localparam int unsigned CapBits     = 8 * BufferBytes;
  localparam int unsigned BitsW       = $clog2(CapBits + 1);
  localparam int unsigned CntW        = $clog2(MaxReadBits + 1);

  localparam int unsigned CmdW     = 2;
  localparam int unsigned DataW    = 8;
  localparam int unsigned CountInW = 6;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned HeldW    = 7;
  localparam int unsigned HeldMax  = (1 << HeldW) - 1;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [CmdW-1:0] CmdPush  = 2'd0;
  localparam logic [CmdW-1:0] CmdRead  = 2'd1;
  localparam logic [CmdW-1:0] CmdAlign = 2'd2;

  localparam logic [StatusW-1:0] StatusOk    = 2'd0;
  localparam logic [StatusW-1:0] StatusUnder = 2'd1;
  localparam logic [StatusW-1:0] StatusFull  = 2'd2;

  typedef enum logic [1:0] {
    OpPush  = 2'd0,
    OpRead  = 2'd1,
    OpAlign = 2'd2,
    OpNop   = 2'd3
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [DataW-1:0] data;
    logic [CntW-1:0]  count;
  } entry_t;

endpackage

/* rtl/core/msbr_front.sv */
module msbr_front (
  input  logic [msbr_pkg::CmdW-1:0]     command_i,
  input  logic [msbr_pkg::DataW-1:0]    data_byte_i,
  input  logic [msbr_pkg::CountInW-1:0] bit_count_i,
  output msbr_pkg::entry_t              entry_o
);

  always_comb begin
    entry_o.data = data_byte_i;
    if (32'(bit_count_i) > msbr_pkg::MaxReadBits) begin
      entry_o.count = msbr_pkg::CntW'(msbr_pkg::MaxReadBits);
    end else begin
      entry_o.count = msbr_pkg::CntW'(bit_count_i);
    end
    unique case (command_i)
      msbr_pkg::CmdPush:  entry_o.op = msbr_pkg::OpPush;
      msbr_pkg::CmdRead:  entry_o.op = msbr_pkg::OpRead;
      msbr_pkg::CmdAlign: entry_o.op = msbr_pkg::OpAlign;
      default:            entry_o.op = msbr_pkg::OpNop;
    endcase
  end

endmodule

/* rtl/core/msbr_queue.sv */
module msbr_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  input  msbr_pkg::entry_t wr_entry_i,
  output logic             full_o,
  input  logic             rd_ready_i,
  output logic             rd_valid_o,
  output msbr_pkg::entry_t rd_entry_o
);

  msbr_pkg::entry_t mem_q [msbr_pkg::QDepth];
  logic [msbr_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [msbr_pkg::QCntW-1:0] cnt_q, cnt_d;
  logic wr_en, rd_en;

  assign full_o     = (32'(cnt_q) == msbr_pkg::QDepth);
  assign rd_valid_o = (cnt_q != '0);
  assign rd_entry_o = mem_q[rd_ptr_q];
  assign wr_en      = wr_valid_i && !full_o;
  assign rd_en      = rd_valid_o && rd_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + msbr_pkg::QCntW'(1);
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - msbr_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_en) begin
        wr_ptr_q <= wr_ptr_q + msbr_pkg::QPtrW'(1);
      end
      if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + msbr_pkg::QPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_entry_i;
    end
  end

endmodule

/* rtl/core/msbr_back.sv */
module msbr_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  msbr_pkg::entry_t                 in_entry_i,
  output logic                             in_ready_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [msbr_pkg::ValueW-1:0]      value_o,
  output logic [msbr_pkg::StatusW-1:0]     status_o,
  output logic [msbr_pkg::HeldW-1:0]       bits_held_o
);

  logic [msbr_pkg::CapBits-1:0] store_q, store_d;
  logic [msbr_pkg::BitsW-1:0]   bits_q, bits_d, shamt;
  logic [msbr_pkg::CapBits-1:0] shifted;
  logic [msbr_pkg::ValueW-1:0]  mask, value_d, value_q;
  logic [msbr_pkg::StatusW-1:0] status_d, status_q;
  logic [msbr_pkg::HeldW-1:0]   held_d, held_q;
  logic                         out_valid_q, fire;

  assign in_ready_o  = !out_valid_q || !out_stall_i;
  assign fire        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;
  assign bits_held_o = held_q;

  assign shamt   = bits_q - msbr_pkg::BitsW'(in_entry_i.count);
  assign shifted = store_q >> shamt;

  always_comb begin
    if (32'(in_entry_i.count) >= msbr_pkg::ValueW) begin
      mask = '1;
    end else begin
      mask = (msbr_pkg::ValueW'(1) << in_entry_i.count) - msbr_pkg::ValueW'(1);
    end
  end

  always_comb begin
    store_d  = store_q;
    bits_d   = bits_q;
    value_d  = '0;
    status_d = msbr_pkg::StatusOk;
    unique case (in_entry_i.op)
      msbr_pkg::OpPush: begin
        if (32'(bits_q) + msbr_pkg::DataW > msbr_pkg::CapBits) begin
          status_d = msbr_pkg::StatusFull;
        end else begin
          store_d = {store_q[msbr_pkg::CapBits-msbr_pkg::DataW-1:0], in_entry_i.data};
          bits_d  = bits_q + msbr_pkg::BitsW'(msbr_pkg::DataW);
        end
      end
      msbr_pkg::OpRead: begin
        if (32'(in_entry_i.count) > 32'(bits_q)) begin
          status_d = msbr_pkg::StatusUnder;
        end else begin
          value_d = shifted[msbr_pkg::ValueW-1:0] & mask;
          bits_d  = shamt;
        end
      end
      msbr_pkg::OpAlign: begin
        bits_d = {bits_q[msbr_pkg::BitsW-1:3], 3'b000};
      end
      default: begin
      end
    endcase
    if (32'(bits_d) > msbr_pkg::HeldMax) begin
      held_d = msbr_pkg::HeldW'(msbr_pkg::HeldMax);
    end else begin
      held_d = msbr_pkg::HeldW'(bits_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q     <= '0;
      bits_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        store_q     <= store_d;
        bits_q      <= bits_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      value_q  <= value_d;
      status_q <= status_d;
      held_q   <= held_d;
    end
  end

endmodule

/* rtl/core/msb_first_bit_reader.sv */
// MSB-first bit reader. Each transaction carries one command: push a byte into the
// 64-bit buffer, read 0 to 32 bits from the oldest end (returned right-aligned), or
// align to the next byte boundary; every command yields exactly one result transaction
// with a status and the number of bits still held. One command is taken every cycle
// while results are taken. A command is written into a two-entry command queue; the
// execute stage, whose 64-bit barrel shifter and buffer update complete one command per
// cycle while the result is not stalled, then takes it and registers the result. A
// stalled result holds the execute stage, and the queue then fills with up to two
// commands before the input is stalled.
`include "assert_macros.svh"

module msb_first_bit_reader (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [msbr_pkg::CmdW-1:0]        command_i,
  input  logic [msbr_pkg::DataW-1:0]       data_byte_i,
  input  logic [msbr_pkg::CountInW-1:0]    bit_count_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [msbr_pkg::ValueW-1:0]      value_o,
  output logic [msbr_pkg::StatusW-1:0]     status_o,
  output logic [msbr_pkg::HeldW-1:0]       bits_held_o
);

  msbr_pkg::entry_t front_entry, q_entry;
  logic q_full, q_valid, back_ready;

  assign in_stall_o = q_full;

  msbr_front u_front (
    .command_i   (command_i),
    .data_byte_i (data_byte_i),
    .bit_count_i (bit_count_i),
    .entry_o     (front_entry)
  );

  msbr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (in_valid_i),
    .wr_entry_i (front_entry),
    .full_o     (q_full),
    .rd_ready_i (back_ready),
    .rd_valid_o (q_valid),
    .rd_entry_o (q_entry)
  );

  msbr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_entry_i  (q_entry),
    .in_ready_o  (back_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .status_o    (status_o),
    .bits_held_o (bits_held_o)
  );

  `ASSERT_NEVER(a_held_cap, clk_i, rst_ni,
                out_valid_o && (32'(bits_held_o) > msbr_pkg::CapBits),
                "More bits held than the buffer can store.")

  `ASSERT_PROP(a_fail_zero, clk_i, rst_ni,
               out_valid_o && (status_o != msbr_pkg::StatusOk) |-> value_o == '0,
               "A failed command returned a non-zero value.")

  `ASSERT_PROP(a_full_real, clk_i, rst_ni,
               out_valid_o && (status_o == msbr_pkg::StatusFull) |->
                 (32'(bits_held_o) + msbr_pkg::DataW > msbr_pkg::CapBits),
               "A byte was dropped although the buffer had room.")

  `ASSERT_PROP(a_drain, clk_i, rst_ni,
               !out_stall_i && !q_valid |=> !out_valid_o,
               "A result transaction was repeated.")

endmodule

/* tb/msb_first_bit_reader_checker.sv */
`timescale 1ns / 1ps

module msb_first_bit_reader_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic [msbr_pkg::CmdW-1:0]           command_i,
  input  logic [msbr_pkg::DataW-1:0]          data_byte_i,
  input  logic [msbr_pkg::CountInW-1:0]       bit_count_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic [msbr_pkg::ValueW-1:0]         value_i,
  input  logic [msbr_pkg::StatusW-1:0]        status_i,
  input  logic [msbr_pkg::HeldW-1:0]          bits_held_i,
  output int                                  pending_o,
  output int                                  error_count_o
);

  typedef struct {
    logic [msbr_pkg::ValueW-1:0]  value;
    logic [msbr_pkg::StatusW-1:0] status;
    logic [msbr_pkg::HeldW-1:0]   held;
  } unpack_result_t;

  logic [msbr_pkg::CapBits-1:0] bit_store;
  int unsigned                  held_bits;
  unpack_result_t               expected_results[$];
  unpack_result_t               oldest;
  int                           mismatches;

  assign error_count_o = mismatches;

  // Unread bits sit in the low held_bits positions of the store, oldest highest.
  function automatic unpack_result_t unpack_command(
      logic [msbr_pkg::CmdW-1:0] cmd,
      logic [msbr_pkg::DataW-1:0] data,
      logic [msbr_pkg::CountInW-1:0] cnt);
    unpack_result_t               r;
    int unsigned                  take;
    logic [msbr_pkg::CapBits-1:0] window;
    r.value  = '0;
    r.status = msbr_pkg::StatusOk;
    case (cmd)
      msbr_pkg::CmdPush: begin
        if (held_bits + 8 > msbr_pkg::CapBits) begin
          r.status = msbr_pkg::StatusFull;
        end else begin
          bit_store = {bit_store[msbr_pkg::CapBits-msbr_pkg::DataW-1:0], data};
          held_bits += 8;
        end
      end
      msbr_pkg::CmdRead: begin
        take = (cnt > msbr_pkg::MaxReadBits) ? msbr_pkg::MaxReadBits : cnt;
        if (take > held_bits) begin
          r.status = msbr_pkg::StatusUnder;
        end else if (take != 0) begin
          window = bit_store >> (held_bits - take);
          window &= {msbr_pkg::CapBits{1'b1}} >> (msbr_pkg::CapBits - take);
          r.value = window[msbr_pkg::ValueW-1:0];
          held_bits -= take;
        end
      end
      msbr_pkg::CmdAlign: begin
        held_bits -= held_bits % 8;
      end
      default: begin
      end
    endcase
    r.held = (held_bits > msbr_pkg::HeldMax) ? msbr_pkg::HeldW'(msbr_pkg::HeldMax)
                                              : msbr_pkg::HeldW'(held_bits);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_store = '0;
      held_bits = 0;
      expected_results.delete();
      mismatches = 0;
      pending_o <= 0;
    end else begin
      // A result is compared before this edge's command is predicted, so that a
      // result with nothing waiting cannot be matched against a fresh expectation.
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no expectation waiting");
          mismatches++;
        end else begin
          oldest = expected_results.pop_front();
          if (value_i !== oldest.value) begin
            $error("value: expected %h, got %h", oldest.value, value_i);
            mismatches++;
          end
          if (status_i !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, status_i);
            mismatches++;
          end
          if (bits_held_i !== oldest.held) begin
            $error("bits_held: expected %0d, got %0d", oldest.held, bits_held_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_results.push_back(unpack_command(command_i, data_byte_i, bit_count_i));
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

/* tb/msb_first_bit_reader_test.sv */
`timescale 1ns / 1ps

module msb_first_bit_reader_test;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                in_valid_i = 1'b0;
  logic                                in_stall_o;
  logic [msbr_pkg::CmdW-1:0]           command_i = msbr_pkg::OpNop;
  logic [msbr_pkg::DataW-1:0]          data_byte_i = '0;
  logic [msbr_pkg::CountInW-1:0]       bit_count_i = '0;
  logic                                out_valid_o;
  logic                                out_stall_i = 1'b0;
  logic [msbr_pkg::ValueW-1:0]         value_o;
  logic [msbr_pkg::StatusW-1:0]        status_o;
  logic [msbr_pkg::HeldW-1:0]          bits_held_o;

  int pending;
  int error_count;
  int cycle_count = 0;
  bit sender_steady = 1'b0;

  msb_first_bit_reader u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .data_byte_i (data_byte_i),
    .bit_count_i (bit_count_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .status_o    (status_o),
    .bits_held_o (bits_held_o)
  );

  msb_first_bit_reader_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .command_i     (command_i),
    .data_byte_i   (data_byte_i),
    .bit_count_i   (bit_count_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .value_i       (value_o),
    .status_i      (status_o),
    .bits_held_i   (bits_held_o),
    .pending_o     (pending),
    .error_count_o (error_count)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= 600 && cycle_count < 1000) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 20);
    end
  end

  // Called and returning at a rising edge; returns at the edge that accepts the transaction.
  task automatic issue_command(input logic [msbr_pkg::CmdW-1:0] cmd,
                               input logic [msbr_pkg::DataW-1:0] data,
                               input logic [msbr_pkg::CountInW-1:0] cnt);
    if (!sender_steady && $urandom_range(0, 99) < 20) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < 20) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    data_byte_i <= data;
    bit_count_i <= cnt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [msbr_pkg::CountInW-1:0] pick_count();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return '0;
    if (roll < 73) return msbr_pkg::CountInW'($urandom_range(1, 16));
    if (roll < 93) return msbr_pkg::CountInW'($urandom_range(17, msbr_pkg::MaxReadBits));
    return msbr_pkg::CountInW'($urandom_range(msbr_pkg::MaxReadBits + 1,
                                              (1 << msbr_pkg::CountInW) - 1));
  endfunction

  initial begin
    logic [msbr_pkg::DataW-1:0] patterns[8];
    int unsigned                push_weight;
    int unsigned                roll;
    patterns = '{8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h80, 8'h01, 8'hC3, 8'h3C};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue_command(msbr_pkg::CmdRead, 8'h00, 6'd1);
    issue_command(msbr_pkg::CmdAlign, 8'h00, 6'd0);
    issue_command(msbr_pkg::OpNop, 8'hFF, 6'h3F);
    issue_command(msbr_pkg::CmdRead, 8'h00, 6'd0);
    foreach (patterns[i]) issue_command(msbr_pkg::CmdPush, patterns[i], 6'd0);
    issue_command(msbr_pkg::CmdPush, 8'h77, 6'd0);
    issue_command(msbr_pkg::CmdRead, 8'h00, 6'd3);
    issue_command(msbr_pkg::CmdAlign, 8'h00, 6'd0);
    issue_command(msbr_pkg::CmdAlign, 8'h00, 6'd0);
    issue_command(msbr_pkg::CmdRead, 8'h00, 6'd63);
    issue_command(msbr_pkg::CmdRead, 8'h00, 6'd33);
    issue_command(msbr_pkg::CmdRead, 8'h00, 6'd24);
    issue_command(msbr_pkg::CmdPush, 8'h96, 6'd0);
    issue_command(msbr_pkg::CmdRead, 8'h00, 6'd32);
    issue_command(msbr_pkg::CmdRead, 8'h00, 6'd8);

    push_weight = 50;
    for (int n = 0; n < 1030; n++) begin
      if (n % 50 == 0) push_weight = $urandom_range(30, 70);
      sender_steady = (n >= 300 && n < 500);
      if (n == 700) drain_results();
      roll = $urandom_range(0, 99);
      if (roll < push_weight) begin
        issue_command(msbr_pkg::CmdPush, msbr_pkg::DataW'($urandom),
                      msbr_pkg::CountInW'($urandom));
      end else if (roll < 88) begin
        issue_command(msbr_pkg::CmdRead, msbr_pkg::DataW'($urandom), pick_count());
      end else if (roll < 96) begin
        issue_command(msbr_pkg::CmdAlign, msbr_pkg::DataW'($urandom),
                      msbr_pkg::CountInW'($urandom));
      end else begin
        issue_command(msbr_pkg::OpNop, msbr_pkg::DataW'($urandom),
                      msbr_pkg::CountInW'($urandom));
      end
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("msb_first_bit_reader_test: done, clean");
    end else begin
      $display("msb_first_bit_reader_test: done, errors");
    end
    $finish;
  end

  initial begin
    #3_600_000;
    $display("msb_first_bit_reader_test: done, errors");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/msbr_pkg.sv
rtl/core/msbr_front.sv
rtl/core/msbr_queue.sv
rtl/core/msbr_back.sv
rtl/core/msb_first_bit_reader.sv
tb/msb_first_bit_reader_checker.sv
tb/msb_first_bit_reader_test.sv
